>>> sv/belr_pkg.sv
// shared types, class codes and helpers for the bidi explicit level resolver
package belr_pkg;

	localparam int CLS_W = 5;
	localparam int LVL_W = 7;
	localparam int OVF_W = 16;

	localparam logic [CLS_W-1:0] CLS_L   = 5'd0;
	localparam logic [CLS_W-1:0] CLS_R   = 5'd1;
	localparam logic [CLS_W-1:0] CLS_BN  = 5'd9;
	localparam logic [CLS_W-1:0] CLS_B   = 5'd10;
	localparam logic [CLS_W-1:0] CLS_LRE = 5'd14;
	localparam logic [CLS_W-1:0] CLS_LRO = 5'd15;
	localparam logic [CLS_W-1:0] CLS_RLE = 5'd16;
	localparam logic [CLS_W-1:0] CLS_RLO = 5'd17;
	localparam logic [CLS_W-1:0] CLS_PDF = 5'd18;
	localparam logic [CLS_W-1:0] CLS_LRI = 5'd19;
	localparam logic [CLS_W-1:0] CLS_RLI = 5'd20;
	localparam logic [CLS_W-1:0] CLS_FSI = 5'd21;
	localparam logic [CLS_W-1:0] CLS_PDI = 5'd22;

	localparam logic [1:0] OVR_NEUTRAL = 2'd0;
	localparam logic [1:0] OVR_LEFT    = 2'd1;
	localparam logic [1:0] OVR_RIGHT   = 2'd2;

	localparam logic [1:0] FSI_UNKNOWN = 2'd0;
	localparam logic [1:0] FSI_RIGHT   = 2'd2;
	localparam logic [1:0] FSI_SPARE   = 2'd3;

	localparam logic [OVF_W-1:0] SAT16 = 16'hffff;

	typedef struct packed {
		logic [CLS_W-1:0] bidi_class;
		logic [1:0]       fsi_direction;
		logic             paragraph_start;
	} in_item_t;

	typedef struct packed {
		logic [LVL_W-1:0] embedding_level;
		logic [CLS_W-1:0] resolved_class;
		logic             removed_by_x9;
		logic             isolate_initiator;
		logic             pop_isolate;
		logic             unmatched_close;
		logic             overflowed;
		logic [LVL_W-1:0] peak_lvl;
	} out_item_t;

	typedef struct packed {
		logic [LVL_W-1:0] level;
		logic [1:0]       ovr;
		logic             iso;
	} entry_t;

	typedef struct packed {
		logic push;
		logic push_iso;
		logic fill;
		logic pdi_pop;
	} step_ctl_t;

	function automatic logic [CLS_W-1:0] with_override(input logic [CLS_W-1:0] cls,
		input logic [1:0] ovr);
		logic [CLS_W-1:0] r;
		r = cls;
		if (ovr == OVR_LEFT) begin
			r = CLS_L;
		end else if (ovr == OVR_RIGHT) begin
			r = CLS_R;
		end
		return r;
	endfunction

endpackage

>>> sv/belr_ram.sv
// simple dual-port synchronous ram with registered read
module belr_ram #(
	parameter int W     = 10,
	parameter int DEPTH = 126,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> sv/belr_step.sv
// next-state and result logic for one code point
module belr_step import belr_pkg::*; #(
	parameter int STACK_DEPTH = 126,
	parameter int MAX_LEVEL   = 125,
	localparam int CNT_W      = $clog2(STACK_DEPTH + 1),
	localparam int ADDR_W     = $clog2(STACK_DEPTH)
) (
	input  in_item_t          it,
	input  logic              base_dir,
	input  logic [LVL_W-1:0]  para_level,
	input  entry_t            top,
	input  logic [CNT_W-1:0]  count,
	input  logic [CNT_W-1:0]  vi,
	input  logic [OVF_W-1:0]  ovi,
	input  logic [OVF_W-1:0]  ove,
	input  logic [LVL_W-1:0]  max_lvl,
	input  logic [ADDR_W-1:0] isotop,
	output step_ctl_t         ctl,
	output out_item_t         res,
	output entry_t            top_n,
	output logic [LVL_W-1:0]  para_n,
	output logic [CNT_W-1:0]  count_n,
	output logic [CNT_W-1:0]  vi_n,
	output logic [OVF_W-1:0]  ovi_n,
	output logic [OVF_W-1:0]  ove_n,
	output logic [LVL_W-1:0]  max_n,
	output logic [ADDR_W-1:0] wr_addr,
	output logic [ADDR_W-1:0] iso_wr_addr,
	output logic [ADDR_W-1:0] rd_addr,
	output logic [ADDR_W-1:0] iso_rd_addr,
	output logic              rd_zero
);

	localparam logic [LVL_W:0] MAX_NL = (LVL_W + 1)'(MAX_LEVEL);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(STACK_DEPTH);

	logic             ps;
	logic [CLS_W-1:0] cls;
	entry_t           e_top;
	logic [CNT_W-1:0] e_cnt;
	logic [CNT_W-1:0] e_vi;
	logic [OVF_W-1:0] e_ovi;
	logic [OVF_W-1:0] e_ove;
	logic [LVL_W-1:0] e_max;
	logic [LVL_W:0]   lvl_x;
	logic [LVL_W:0]   nl_even;
	logic [LVL_W:0]   nl_odd;
	logic [LVL_W:0]   nl;
	logic             is_emb;
	logic             is_iso;
	logic             right;
	logic             can_push;
	logic [1:0]       push_ovr;
	logic [CNT_W-1:0] cnt_m2;
	logic [CNT_W-1:0] vi_m2;

	always_comb begin
		ps    = it.paragraph_start;
		cls   = it.bidi_class;
		e_top = top;
		e_cnt = count;
		e_vi  = vi;
		e_ovi = ovi;
		e_ove = ove;
		e_max = max_lvl;
		para_n = para_level;
		if (ps) begin
			e_top  = '{level: LVL_W'(base_dir), ovr: OVR_NEUTRAL, iso: 1'b0};
			e_cnt  = CNT_W'(1);
			e_vi   = '0;
			e_ovi  = '0;
			e_ove  = '0;
			e_max  = LVL_W'(base_dir);
			para_n = LVL_W'(base_dir);
		end

		lvl_x   = {1'b0, e_top.level};
		nl_even = (lvl_x + (LVL_W + 1)'(2)) & ~(LVL_W + 1)'(1);
		nl_odd  = (lvl_x + (LVL_W + 1)'(1)) | (LVL_W + 1)'(1);

		is_emb = (cls >= CLS_LRE) && (cls <= CLS_RLO);
		is_iso = (cls >= CLS_LRI) && (cls <= CLS_FSI);
		if (cls == CLS_FSI) begin
			right = (it.fsi_direction == FSI_RIGHT) ||
				(((it.fsi_direction == FSI_UNKNOWN) || (it.fsi_direction == FSI_SPARE)) &&
				base_dir);
		end else begin
			right = (cls == CLS_RLE) || (cls == CLS_RLO) || (cls == CLS_RLI);
		end
		nl       = right ? nl_odd : nl_even;
		can_push = (nl <= MAX_NL) && (e_ovi == '0) && (e_ove == '0) && (e_cnt < DEPTH_C);
		push_ovr = (cls == CLS_LRO) ? OVR_LEFT : ((cls == CLS_RLO) ? OVR_RIGHT : OVR_NEUTRAL);

		cnt_m2 = e_cnt - CNT_W'(2);
		vi_m2  = e_vi - CNT_W'(2);

		ctl         = '0;
		top_n       = e_top;
		count_n     = e_cnt;
		vi_n        = e_vi;
		ovi_n       = e_ovi;
		ove_n       = e_ove;
		max_n       = e_max;
		wr_addr     = e_cnt[ADDR_W-1:0];
		iso_wr_addr = e_vi[ADDR_W-1:0];
		rd_addr     = cnt_m2[ADDR_W-1:0];
		iso_rd_addr = vi_m2[ADDR_W-1:0];

		res                   = '0;
		res.embedding_level   = e_top.level;
		res.resolved_class    = with_override(cls, e_top.ovr);

		priority if (is_emb) begin
			res.removed_by_x9  = 1'b1;
			res.resolved_class = cls;
			if (can_push) begin
				ctl.push = 1'b1;
			end else begin
				res.overflowed = 1'b1;
				if ((e_ovi == '0) && (e_ove != SAT16)) begin
					ove_n = e_ove + OVF_W'(1);
				end
			end
		end else if (is_iso) begin
			res.isolate_initiator = 1'b1;
			if (can_push) begin
				ctl.push     = 1'b1;
				ctl.push_iso = 1'b1;
				vi_n         = e_vi + CNT_W'(1);
			end else begin
				res.overflowed = 1'b1;
				if (e_ovi != SAT16) begin
					ovi_n = e_ovi + OVF_W'(1);
				end
			end
		end else if (cls == CLS_PDF) begin
			res.removed_by_x9  = 1'b1;
			res.resolved_class = cls;
			if (e_ovi != '0) begin
				res.unmatched_close = 1'b1;
			end else if (e_ove != '0) begin
				ove_n = e_ove - OVF_W'(1);
			end else if ((e_cnt > CNT_W'(1)) && !e_top.iso) begin
				count_n  = e_cnt - CNT_W'(1);
				ctl.fill = 1'b1;
			end else begin
				res.unmatched_close = 1'b1;
			end
		end else if (cls == CLS_PDI) begin
			res.pop_isolate = 1'b1;
			if (e_ovi != '0) begin
				ovi_n = e_ovi - OVF_W'(1);
			end else if (e_vi == '0) begin
				res.unmatched_close = 1'b1;
			end else begin
				ove_n       = '0;
				count_n     = CNT_W'(isotop);
				vi_n        = e_vi - CNT_W'(1);
				rd_addr     = isotop - ADDR_W'(1);
				ctl.fill    = 1'b1;
				ctl.pdi_pop = 1'b1;
			end
		end else if (cls == CLS_BN) begin
			res.removed_by_x9  = 1'b1;
			res.resolved_class = cls;
		end else if (cls == CLS_B) begin
			res.embedding_level = LVL_W'(base_dir);
			res.resolved_class  = cls;
		end else begin
			res.resolved_class = with_override(cls, e_top.ovr);
		end

		if (ctl.push) begin
			count_n = e_cnt + CNT_W'(1);
			top_n   = '{level: nl[LVL_W-1:0], ovr: ctl.push_iso ? OVR_NEUTRAL : push_ovr,
				iso: ctl.push_iso};
			if (nl[LVL_W-1:0] > e_max) begin
				max_n = nl[LVL_W-1:0];
			end
		end

		rd_zero      = (rd_addr == '0);
		res.peak_lvl = max_n;
	end

endmodule

>>> sv/bidi_explicit_level_resolver_unit.sv
// top level of the bidi explicit level resolver
//
//  channel  | signals                          | payload
//  ---------+----------------------------------+--------------------------
//  item     | item_valid, item_ready, item     | in_item_t
//  result   | result_valid, result_ready, result | out_item_t
//  cfg      | cfg_valid, cfg_ready, cfg_data   | paragraph direction, 1 bit
//
//  one code point per cycle unless the result side stalls; a PDF that pops and a PDI
//  closing a valid isolate also wait in ST_FILL for the stack ram read of the new top
//  the isolate position ram gives the PDI target in a single step
//  reset clears counters and the cached top entry; the stack rams are not cleared,
//  entry 0 lives in a register and entries above the count are never read
//  a one-item input register and the result register decouple the two sides
module bidi_explicit_level_resolver_unit import belr_pkg::*; #(
	parameter int STACK_DEPTH = 126,
	parameter int MAX_LEVEL   = 125
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_ready,
	input  in_item_t  item,
	output logic      result_valid,
	input  logic      result_ready,
	output out_item_t result,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  logic      cfg_data
);

	localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W  = $clog2(STACK_DEPTH);
	localparam int ENTRY_W = $bits(entry_t);

	localparam logic ST_RUN  = 1'b0;
	localparam logic ST_FILL = 1'b1;

	logic              state_q;
	logic              base_q;
	logic              item_valid_q;
	in_item_t          item_q;
	logic              result_valid_q;
	out_item_t         result_q;
	entry_t            top_q;
	logic [LVL_W-1:0]  para_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  vi_q;
	logic [OVF_W-1:0]  ovi_q;
	logic [OVF_W-1:0]  ove_q;
	logic [LVL_W-1:0]  max_q;
	logic [ADDR_W-1:0] isotop_q;
	logic              pdi_pend_q;
	logic              rd_zero_q;

	step_ctl_t         ctl;
	out_item_t         res;
	entry_t            top_n;
	logic [LVL_W-1:0]  para_n;
	logic [CNT_W-1:0]  count_n;
	logic [CNT_W-1:0]  vi_n;
	logic [OVF_W-1:0]  ovi_n;
	logic [OVF_W-1:0]  ove_n;
	logic [LVL_W-1:0]  max_n;
	logic [ADDR_W-1:0] wr_addr;
	logic [ADDR_W-1:0] iso_wr_addr;
	logic [ADDR_W-1:0] rd_addr;
	logic [ADDR_W-1:0] iso_rd_addr;
	logic              rd_zero;
	logic [ENTRY_W-1:0] stack_rdata;
	logic [ADDR_W-1:0] iso_rdata;
	entry_t            fill_top;
	logic              exec_go;

	assign exec_go      = item_valid_q && (state_q == ST_RUN) && (!result_valid_q || result_ready);
	assign item_ready   = !item_valid_q || exec_go;
	assign cfg_ready    = 1'b1;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	assign fill_top = rd_zero_q ? entry_t'{level: para_q, ovr: OVR_NEUTRAL, iso: 1'b0} :
		entry_t'(stack_rdata);

	belr_step #(
		.STACK_DEPTH(STACK_DEPTH),
		.MAX_LEVEL  (MAX_LEVEL)
	) u_step (
		.it         (item_q),
		.base_dir   (base_q),
		.para_level (para_q),
		.top        (top_q),
		.count      (count_q),
		.vi         (vi_q),
		.ovi        (ovi_q),
		.ove        (ove_q),
		.max_lvl    (max_q),
		.isotop     (isotop_q),
		.ctl        (ctl),
		.res        (res),
		.top_n      (top_n),
		.para_n     (para_n),
		.count_n    (count_n),
		.vi_n       (vi_n),
		.ovi_n      (ovi_n),
		.ove_n      (ove_n),
		.max_n      (max_n),
		.wr_addr    (wr_addr),
		.iso_wr_addr(iso_wr_addr),
		.rd_addr    (rd_addr),
		.iso_rd_addr(iso_rd_addr),
		.rd_zero    (rd_zero)
	);

	// status stack, entry 0 held in para_q
	belr_ram #(
		.W    (ENTRY_W),
		.DEPTH(STACK_DEPTH)
	) u_stack_ram (
		.clk  (clk),
		.we   (exec_go && ctl.push),
		.waddr(wr_addr),
		.wdata(top_n),
		.re   (exec_go && ctl.fill),
		.raddr(rd_addr),
		.rdata(stack_rdata)
	);

	// stack positions of open valid isolates
	belr_ram #(
		.W    (ADDR_W),
		.DEPTH(STACK_DEPTH)
	) u_iso_ram (
		.clk  (clk),
		.we   (exec_go && ctl.push_iso),
		.waddr(iso_wr_addr),
		.wdata(wr_addr),
		.re   (exec_go && ctl.pdi_pop),
		.raddr(iso_rd_addr),
		.rdata(iso_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_RUN;
			base_q         <= 1'b0;
			item_valid_q   <= 1'b0;
			result_valid_q <= 1'b0;
			top_q          <= '{level: '0, ovr: OVR_NEUTRAL, iso: 1'b0};
			para_q         <= '0;
			count_q        <= CNT_W'(1);
			vi_q           <= '0;
			ovi_q          <= '0;
			ove_q          <= '0;
			max_q          <= '0;
			isotop_q       <= '0;
			pdi_pend_q     <= 1'b0;
			rd_zero_q      <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				base_q <= cfg_data;
			end
			if (item_ready) begin
				item_valid_q <= item_valid;
			end
			if (exec_go) begin
				count_q    <= count_n;
				vi_q       <= vi_n;
				ovi_q      <= ovi_n;
				ove_q      <= ove_n;
				max_q      <= max_n;
				top_q      <= top_n;
				para_q     <= para_n;
				pdi_pend_q <= ctl.pdi_pop;
				rd_zero_q  <= rd_zero;
				if (ctl.push_iso) begin
					isotop_q <= wr_addr;
				end
				if (ctl.fill) begin
					state_q <= ST_FILL;
				end
			end else if (state_q == ST_FILL) begin
				top_q   <= fill_top;
				state_q <= ST_RUN;
				if (pdi_pend_q) begin
					isotop_q <= iso_rdata;
				end
			end
			priority if ((exec_go && !ctl.pdi_pop) || ((state_q == ST_FILL) && pdi_pend_q)) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_q <= item;
		end
		if (exec_go) begin
			result_q <= res;
		end else if ((state_q == ST_FILL) && pdi_pend_q) begin
			result_q.embedding_level <= fill_top.level;
			result_q.resolved_class  <= with_override(CLS_PDI, fill_top.ovr);
		end
	end

endmodule

>>> sv/belr_checker.sv
// port-level checker for the bidi explicit level resolver, with its bind
module belr_checker import belr_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      result_valid,
	input logic      result_ready,
	input out_item_t result
);

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	a_overflow_kind: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.overflowed |->
		result.isolate_initiator || result.removed_by_x9)
		else $error("overflow flag on a non-initiator");

	a_removed_class: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.removed_by_x9 |->
		(result.resolved_class == CLS_BN) || (result.resolved_class == CLS_LRE) ||
		(result.resolved_class == CLS_LRO) || (result.resolved_class == CLS_RLE) ||
		(result.resolved_class == CLS_RLO) || (result.resolved_class == CLS_PDF))
		else $error("removed mark on a class that stays");

	a_unmatched_kind: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.unmatched_close |->
		result.pop_isolate || (result.resolved_class == CLS_PDF))
		else $error("unmatched flag on a non-closing class");

endmodule

bind bidi_explicit_level_resolver_unit belr_checker u_belr_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.result_valid(result_valid),
	.result_ready(result_ready),
	.result      (result)
);
